/* sv/tbrf_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tbrf_pkg
// Shared types, register indexes and the CRC-8 step of the byte relay framer.
// ----------------------------------------------------------------------------
package tbrf_pkg;

    localparam logic [7:0] CRC_POLY = 8'h07;

    localparam logic [2:0] REG_GAP_LIMIT   = 3'd0;
    localparam logic [2:0] REG_FLAG        = 3'd1;
    localparam logic [2:0] REG_ESCAPE      = 3'd2;
    localparam logic [2:0] REG_ESC_FLAG    = 3'd3;
    localparam logic [2:0] REG_ESC_ESCAPE  = 3'd4;
    localparam logic [2:0] REG_STATUS_CODE = 3'd5;
    localparam logic [2:0] REG_DATA_CODE   = 3'd6;

    localparam logic [1:0] REQ_BYTE  = 2'd0;
    localparam logic [1:0] REQ_DROPS = 2'd1;
    localparam logic [1:0] REQ_POLL  = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_FIT,
        S_OPEN,
        S_BODY,
        S_CLOSE,
        S_DATA,
        S_MK_RD,
        S_MK_CHK,
        S_HDR,
        S_LOAD,
        S_LOADW
    } t_state;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        frame_end;
        logic        last;
        logic [31:0] dropped_total;
    } t_beat;

    function automatic logic [7:0] crc8_step(input logic [7:0] c, input logic [7:0] b);
        logic [7:0] x;
        x = c ^ b;
        for (int i = 0; i < 8; i++) begin
            x = x[7] ? ((x << 1) ^ CRC_POLY) : (x << 1);
        end
        return x;
    endfunction

endpackage
`default_nettype wire

/* sv/tbrf_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tbrf_store
// Byte ring and mark ring memories, one write and one registered read each.
// ----------------------------------------------------------------------------
module tbrf_store #(
    parameter int RING_DEPTH = 512,
    parameter int MARK_DEPTH = 32
) (
    input  wire                                i_clk,
    input  wire                                i_byte_we,
    input  wire [$clog2(RING_DEPTH)-1:0]       i_byte_waddr,
    input  wire [7:0]                          i_byte_wdata,
    input  wire [$clog2(RING_DEPTH)-1:0]       i_byte_raddr,
    output logic [7:0]                         o_byte_rdata,
    input  wire                                i_mark_we,
    input  wire [$clog2(MARK_DEPTH)-1:0]       i_mark_waddr,
    input  wire [$clog2(2*RING_DEPTH)-1:0]     i_mark_wpos,
    input  wire [31:0]                         i_mark_wtime,
    input  wire [$clog2(MARK_DEPTH)-1:0]       i_mark_raddr,
    output logic [$clog2(2*RING_DEPTH)-1:0]    o_mark_rpos,
    output logic [31:0]                        o_mark_rtime
);
    localparam int PW = $clog2(2*RING_DEPTH);

    logic [7:0]    r_byte_mem [RING_DEPTH];
    logic [PW-1:0] r_pos_mem  [MARK_DEPTH];
    logic [31:0]   r_time_mem [MARK_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_byte_we) begin
            r_byte_mem[i_byte_waddr] <= i_byte_wdata;
        end
        o_byte_rdata <= r_byte_mem[i_byte_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_mark_we) begin
            r_pos_mem[i_mark_waddr]  <= i_mark_wpos;
            r_time_mem[i_mark_waddr] <= i_mark_wtime;
        end
        o_mark_rpos  <= r_pos_mem[i_mark_raddr];
        o_mark_rtime <= r_time_mem[i_mark_raddr];
    end

endmodule
`default_nettype wire

/* sv/tbrf_tx_reg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tbrf_tx_reg
// Output register holding one encoded beat until the sink takes it.
// ----------------------------------------------------------------------------
module tbrf_tx_reg (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_load,
    input  wire tbrf_pkg::t_beat i_beat,
    input  wire                 i_out_ready,
    output logic                o_out_valid,
    output tbrf_pkg::t_beat     o_beat,
    output logic                o_can_load
);
    logic r_valid;
    tbrf_pkg::t_beat r_beat;

    assign o_can_load  = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_beat      = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_beat <= i_beat;
        end
    end

endmodule
`default_nettype wire

/* sv/timestamped_byte_relay_framer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// timestamped_byte_relay_framer
// Captures timestamped bytes and burst marks into rings and sends them as
// SLIP-stuffed frames with CRC-8 on poll.
// ----------------------------------------------------------------------------
// A byte capture or a drop update is done in idle and the next item may follow
// at once. A poll holds the block out of idle: it sizes the frame one raw byte
// per cycle, passes S_MK_RD and S_MK_CHK per skipped burst mark and S_LOAD and
// S_LOADW per payload byte, as the mark and byte ring memories have a registered
// read, and sends one encoded beat per cycle while the sink takes beats.
module timestamped_byte_relay_framer #(
    parameter int RING_DEPTH  = 512,
    parameter int MARK_DEPTH  = 32,
    parameter int CHUNK_BYTES = 12
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [1:0]  i_req_type,
    input  wire  [7:0]  i_data_byte,
    input  wire  [31:0] i_arrival_time,
    input  wire  [31:0] i_drop_count,
    input  wire  [7:0]  i_sink_room,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_frame_end,
    output logic        o_last,
    output logic [31:0] o_dropped_total,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int RW       = $clog2(RING_DEPTH);
    localparam int PW       = $clog2(2*RING_DEPTH);
    localparam int MW       = $clog2(MARK_DEPTH);
    localparam int MPW      = $clog2(2*MARK_DEPTH);
    localparam int NW       = $clog2(CHUNK_BYTES+1);
    localparam int FB_DEPTH = CHUNK_BYTES + 8;
    localparam int FBW      = $clog2(FB_DEPTH);

    localparam logic [PW-1:0]  RD_P  = PW'(RING_DEPTH);
    localparam logic [PW:0]    RD2_P = (PW+1)'(2*RING_DEPTH);
    localparam logic [MPW-1:0] MD_P  = MPW'(MARK_DEPTH);
    localparam logic [MPW:0]   MD2_P = (MPW+1)'(2*MARK_DEPTH);

    tbrf_pkg::t_state r_state, n_state;

    logic [31:0] r_gap;
    logic [7:0]  r_flag, r_esc, r_eflag, r_eesc, r_scode, r_dcode;

    logic [PW-1:0]  r_wp, n_wp, r_rp, n_rp;
    logic [MPW-1:0] r_mwp, n_mwp, r_mrp, n_mrp;
    logic [31:0]    r_prev, n_prev, r_drops, n_drops, r_burst, n_burst, r_rep, n_rep;
    logic           r_prevv, n_prevv;
    logic [7:0]     r_seq, n_seq, r_room, n_room, r_crc, n_crc;
    logic           r_pend, n_pend, r_go, n_go, r_is_st, n_is_st, r_esc2, n_esc2;
    logic [NW-1:0]  r_n, n_n, r_li, n_li;
    logic [FBW-1:0] r_idx, n_idx, r_cnt, n_cnt;
    logic [5:0]     r_len, n_len;
    logic [7:0]     r_fb [FB_DEPTH];
    logic [7:0]     n_fb [FB_DEPTH];

    logic           w_acc, w_can_load, w_load;
    tbrf_pkg::t_beat w_beat, w_obeat;
    logic [PW:0]    w_used_x, w_d_x, w_ld_x, w_rp_x;
    logic [PW-1:0]  w_used, w_d, w_ld_p, w_ld_f, w_wp_f, w_rp_next;
    logic [MPW:0]   w_mused_x;
    logic [MPW-1:0] w_mused, w_mwp_f, w_mrp_f;
    logic [PW-1:0]  w_mpos;
    logic [31:0]    w_mtime;
    logic [7:0]     w_brd;
    logic           w_byte_we, w_mark_we;
    logic           w_fits, w_body_done, w_mark_break, w_load_done, w_prep_done;
    logic [5:0]     w_tot;
    logic [7:0]     w_cur;
    logic           w_cur_st, w_crc_st;
    logic [31:0]    w_gap;
    logic           w_cfg_we;

    assign o_in_ready = (r_state == tbrf_pkg::S_IDLE);
    assign w_acc      = i_in_valid && o_in_ready;

    assign pready   = 1'b1;
    assign w_cfg_we = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap   <= 32'd1000;
            r_flag  <= 8'd192;
            r_esc   <= 8'd219;
            r_eflag <= 8'd220;
            r_eesc  <= 8'd221;
            r_scode <= 8'd2;
            r_dcode <= 8'd1;
        end else if (w_cfg_we) begin
            case (paddr[4:2])
                tbrf_pkg::REG_GAP_LIMIT:   r_gap   <= pwdata;
                tbrf_pkg::REG_FLAG:        r_flag  <= pwdata[7:0];
                tbrf_pkg::REG_ESCAPE:      r_esc   <= pwdata[7:0];
                tbrf_pkg::REG_ESC_FLAG:    r_eflag <= pwdata[7:0];
                tbrf_pkg::REG_ESC_ESCAPE:  r_eesc  <= pwdata[7:0];
                tbrf_pkg::REG_STATUS_CODE: r_scode <= pwdata[7:0];
                tbrf_pkg::REG_DATA_CODE:   r_dcode <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            tbrf_pkg::REG_GAP_LIMIT:   prdata = r_gap;
            tbrf_pkg::REG_FLAG:        prdata = {24'd0, r_flag};
            tbrf_pkg::REG_ESCAPE:      prdata = {24'd0, r_esc};
            tbrf_pkg::REG_ESC_FLAG:    prdata = {24'd0, r_eflag};
            tbrf_pkg::REG_ESC_ESCAPE:  prdata = {24'd0, r_eesc};
            tbrf_pkg::REG_STATUS_CODE: prdata = {24'd0, r_scode};
            tbrf_pkg::REG_DATA_CODE:   prdata = {24'd0, r_dcode};
            default:                   prdata = 32'd0;
        endcase
    end

    always_comb begin
        w_used_x = {1'b0, r_wp} + RD2_P - {1'b0, r_rp};
        if (w_used_x >= RD2_P) begin
            w_used_x = w_used_x - RD2_P;
        end
        w_used = w_used_x[PW-1:0];

        w_mused_x = {1'b0, r_mwp} + MD2_P - {1'b0, r_mrp};
        if (w_mused_x >= MD2_P) begin
            w_mused_x = w_mused_x - MD2_P;
        end
        w_mused = w_mused_x[MPW-1:0];

        w_d_x = {1'b0, w_mpos} + RD2_P - {1'b0, r_rp};
        if (w_d_x >= RD2_P) begin
            w_d_x = w_d_x - RD2_P;
        end
        w_d = w_d_x[PW-1:0];

        w_ld_x = {1'b0, r_rp} + (PW+1)'(r_li);
        if (w_ld_x >= RD2_P) begin
            w_ld_x = w_ld_x - RD2_P;
        end
        w_ld_p = w_ld_x[PW-1:0];

        w_rp_x = {1'b0, r_rp} + (PW+1)'(r_n);
        if (w_rp_x >= RD2_P) begin
            w_rp_x = w_rp_x - RD2_P;
        end
        w_rp_next = w_rp_x[PW-1:0];

        w_ld_f = (w_ld_p >= RD_P) ? (w_ld_p - RD_P) : w_ld_p;
        w_wp_f = (r_wp >= RD_P) ? (r_wp - RD_P) : r_wp;
        w_mwp_f = (r_mwp >= MD_P) ? (r_mwp - MD_P) : r_mwp;
        w_mrp_f = (r_mrp >= MD_P) ? (r_mrp - MD_P) : r_mrp;
    end

    assign w_gap        = i_arrival_time - r_prev;
    assign w_cur        = r_fb[r_idx];
    assign w_cur_st     = (w_cur == r_flag) || (w_cur == r_esc);
    assign w_crc_st     = (r_crc == r_flag) || (r_crc == r_esc);
    assign w_tot        = r_len + (w_crc_st ? 6'd2 : 6'd1) + 6'd2;
    assign w_fits       = {2'd0, w_tot} <= r_room;
    assign w_body_done  = (r_esc2 || !w_cur_st) && (r_idx == r_cnt);
    assign w_mark_break = (w_d != '0) && (w_d < RD_P);
    assign w_load_done  = (32'(r_li) + 32'd1) == 32'(r_n);
    assign w_prep_done  = (r_idx == (r_cnt - FBW'(1)));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tbrf_pkg::S_IDLE: begin
                if (w_acc && i_req_type == tbrf_pkg::REQ_POLL) begin
                    n_state = (r_drops != r_rep) ? tbrf_pkg::S_PREP : tbrf_pkg::S_DATA;
                end
            end
            tbrf_pkg::S_PREP: begin
                if (w_prep_done) begin
                    n_state = tbrf_pkg::S_FIT;
                end
            end
            tbrf_pkg::S_FIT: begin
                if (r_is_st) begin
                    n_state = w_fits ? tbrf_pkg::S_OPEN : tbrf_pkg::S_IDLE;
                end else if (r_pend) begin
                    n_state = tbrf_pkg::S_CLOSE;
                end else begin
                    n_state = w_fits ? tbrf_pkg::S_OPEN : tbrf_pkg::S_IDLE;
                end
            end
            tbrf_pkg::S_OPEN: begin
                if (w_can_load) begin
                    n_state = tbrf_pkg::S_BODY;
                end
            end
            tbrf_pkg::S_BODY: begin
                if (w_can_load && w_body_done) begin
                    n_state = r_is_st ? tbrf_pkg::S_DATA : tbrf_pkg::S_CLOSE;
                end
            end
            tbrf_pkg::S_CLOSE: begin
                if (w_can_load) begin
                    n_state = r_go ? tbrf_pkg::S_OPEN : tbrf_pkg::S_IDLE;
                end
            end
            tbrf_pkg::S_DATA: begin
                if (w_used == '0) begin
                    n_state = r_pend ? tbrf_pkg::S_CLOSE : tbrf_pkg::S_IDLE;
                end else begin
                    n_state = tbrf_pkg::S_MK_RD;
                end
            end
            tbrf_pkg::S_MK_RD: begin
                n_state = (r_mrp == r_mwp) ? tbrf_pkg::S_HDR : tbrf_pkg::S_MK_CHK;
            end
            tbrf_pkg::S_MK_CHK: begin
                n_state = w_mark_break ? tbrf_pkg::S_HDR : tbrf_pkg::S_MK_RD;
            end
            tbrf_pkg::S_HDR:   n_state = tbrf_pkg::S_LOAD;
            tbrf_pkg::S_LOAD:  n_state = tbrf_pkg::S_LOADW;
            tbrf_pkg::S_LOADW: begin
                n_state = w_load_done ? tbrf_pkg::S_PREP : tbrf_pkg::S_LOAD;
            end
            default: n_state = tbrf_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_wp    = r_wp;
        n_rp    = r_rp;
        n_mwp   = r_mwp;
        n_mrp   = r_mrp;
        n_prev  = r_prev;
        n_prevv = r_prevv;
        n_drops = r_drops;
        n_burst = r_burst;
        n_rep   = r_rep;
        n_seq   = r_seq;
        n_room  = r_room;
        n_crc   = r_crc;
        n_pend  = r_pend;
        n_go    = r_go;
        n_is_st = r_is_st;
        n_esc2  = r_esc2;
        n_n     = r_n;
        n_li    = r_li;
        n_idx   = r_idx;
        n_cnt   = r_cnt;
        n_len   = r_len;
        n_fb    = r_fb;
        w_byte_we = 1'b0;
        w_mark_we = 1'b0;
        w_load    = 1'b0;
        w_beat.out_byte      = r_flag;
        w_beat.frame_end     = 1'b0;
        w_beat.last          = 1'b0;
        w_beat.dropped_total = r_drops;

        unique case (r_state)
            tbrf_pkg::S_IDLE: begin
                if (w_acc) begin
                    case (i_req_type)
                        tbrf_pkg::REQ_BYTE: begin
                            if (w_used >= RD_P) begin
                                n_drops = r_drops + 32'd1;
                            end else begin
                                if (!r_prevv || w_gap > r_gap) begin
                                    if (w_mused < MD_P) begin
                                        w_mark_we = 1'b1;
                                        n_mwp = ((MPW+1)'(r_mwp) + 1'b1 == MD2_P) ? '0
                                                : r_mwp + 1'b1;
                                    end else begin
                                        n_drops = r_drops + 32'd1;
                                    end
                                end
                                n_prev    = i_arrival_time;
                                n_prevv   = 1'b1;
                                w_byte_we = 1'b1;
                                n_wp = ((PW+1)'(r_wp) + 1'b1 == RD2_P) ? '0 : r_wp + 1'b1;
                            end
                        end
                        tbrf_pkg::REQ_DROPS: begin
                            n_drops = r_drops + i_drop_count;
                        end
                        tbrf_pkg::REQ_POLL: begin
                            n_room  = i_sink_room;
                            n_go    = 1'b0;
                            n_pend  = 1'b0;
                            n_is_st = 1'b1;
                            n_idx   = '0;
                            n_crc   = 8'd0;
                            n_len   = 6'd0;
                            n_cnt   = FBW'(7);
                            n_fb[0] = r_scode;
                            n_fb[1] = r_seq;
                            n_fb[2] = 8'd4;
                            n_fb[3] = r_drops[7:0];
                            n_fb[4] = r_drops[15:8];
                            n_fb[5] = r_drops[23:16];
                            n_fb[6] = r_drops[31:24];
                        end
                        default: ;
                    endcase
                end
            end
            tbrf_pkg::S_PREP: begin
                n_crc = tbrf_pkg::crc8_step(r_crc, w_cur);
                n_len = r_len + (w_cur_st ? 6'd2 : 6'd1);
                n_idx = r_idx + FBW'(1);
            end
            tbrf_pkg::S_FIT: begin
                n_fb[r_cnt] = r_crc;
                n_idx  = '0;
                n_esc2 = 1'b0;
                if (w_fits) begin
                    n_seq = r_seq + 8'd1;
                    if (r_is_st) begin
                        n_room = r_room - {2'd0, w_tot};
                        n_rep  = r_drops;
                    end else begin
                        n_go = 1'b1;
                        n_rp = w_rp_next;
                    end
                end else begin
                    n_go = 1'b0;
                end
            end
            tbrf_pkg::S_OPEN: begin
                if (w_can_load) begin
                    w_load = 1'b1;
                    n_go   = 1'b0;
                end
            end
            tbrf_pkg::S_BODY: begin
                if (w_can_load) begin
                    w_load = 1'b1;
                    if (r_esc2) begin
                        w_beat.out_byte = (w_cur == r_flag) ? r_eflag : r_eesc;
                        n_esc2 = 1'b0;
                        n_idx  = r_idx + FBW'(1);
                    end else if (w_cur_st) begin
                        w_beat.out_byte = r_esc;
                        n_esc2 = 1'b1;
                    end else begin
                        w_beat.out_byte = w_cur;
                        n_idx = r_idx + FBW'(1);
                    end
                    if (w_body_done && r_is_st) begin
                        n_pend = 1'b1;
                    end
                end
            end
            tbrf_pkg::S_CLOSE: begin
                if (w_can_load) begin
                    w_load           = 1'b1;
                    w_beat.frame_end = 1'b1;
                    w_beat.last      = !r_go;
                    n_pend           = 1'b0;
                    n_is_st          = 1'b0;
                end
            end
            tbrf_pkg::S_DATA: begin
                n_go = 1'b0;
                n_n  = (32'(w_used) > 32'(CHUNK_BYTES)) ? NW'(CHUNK_BYTES) : NW'(w_used);
            end
            tbrf_pkg::S_MK_RD: ;
            tbrf_pkg::S_MK_CHK: begin
                if (w_mark_break) begin
                    if (32'(w_d) < 32'(r_n)) begin
                        n_n = NW'(w_d);
                    end
                end else begin
                    n_burst = w_mtime;
                    n_mrp = ((MPW+1)'(r_mrp) + 1'b1 == MD2_P) ? '0 : r_mrp + 1'b1;
                end
            end
            tbrf_pkg::S_HDR: begin
                n_fb[0] = r_dcode;
                n_fb[1] = r_seq;
                n_fb[2] = 8'(32'd4 + 32'(r_n));
                n_fb[3] = r_burst[7:0];
                n_fb[4] = r_burst[15:8];
                n_fb[5] = r_burst[23:16];
                n_fb[6] = r_burst[31:24];
                n_cnt   = FBW'(32'd7 + 32'(r_n));
                n_li    = '0;
                n_is_st = 1'b0;
            end
            tbrf_pkg::S_LOAD: ;
            tbrf_pkg::S_LOADW: begin
                n_fb[FBW'(32'd7 + 32'(r_li))] = w_brd;
                n_li = r_li + NW'(1);
                if (w_load_done) begin
                    n_idx = '0;
                    n_crc = 8'd0;
                    n_len = 6'd0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tbrf_pkg::S_IDLE;
            r_wp    <= '0;
            r_rp    <= '0;
            r_mwp   <= '0;
            r_mrp   <= '0;
            r_prev  <= 32'd0;
            r_prevv <= 1'b0;
            r_drops <= 32'd0;
            r_burst <= 32'd0;
            r_rep   <= 32'd0;
            r_seq   <= 8'd0;
            r_pend  <= 1'b0;
            r_go    <= 1'b0;
            r_is_st <= 1'b0;
            r_esc2  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_mwp   <= n_mwp;
            r_mrp   <= n_mrp;
            r_prev  <= n_prev;
            r_prevv <= n_prevv;
            r_drops <= n_drops;
            r_burst <= n_burst;
            r_rep   <= n_rep;
            r_seq   <= n_seq;
            r_pend  <= n_pend;
            r_go    <= n_go;
            r_is_st <= n_is_st;
            r_esc2  <= n_esc2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_room <= n_room;
        r_crc  <= n_crc;
        r_n    <= n_n;
        r_li   <= n_li;
        r_idx  <= n_idx;
        r_cnt  <= n_cnt;
        r_len  <= n_len;
        r_fb   <= n_fb;
    end

    tbrf_store #(
        .RING_DEPTH (RING_DEPTH),
        .MARK_DEPTH (MARK_DEPTH)
    ) u_store (
        .i_clk        (i_clk),
        .i_byte_we    (w_byte_we),
        .i_byte_waddr (w_wp_f[RW-1:0]),
        .i_byte_wdata (i_data_byte),
        .i_byte_raddr (w_ld_f[RW-1:0]),
        .o_byte_rdata (w_brd),
        .i_mark_we    (w_mark_we),
        .i_mark_waddr (w_mwp_f[MW-1:0]),
        .i_mark_wpos  (r_wp),
        .i_mark_wtime (i_arrival_time),
        .i_mark_raddr (w_mrp_f[MW-1:0]),
        .o_mark_rpos  (w_mpos),
        .o_mark_rtime (w_mtime)
    );

    tbrf_tx_reg u_tx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_beat      (w_beat),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_beat      (w_obeat),
        .o_can_load  (w_can_load)
    );

    assign o_out_byte      = w_obeat.out_byte;
    assign o_frame_end     = w_obeat.frame_end;
    assign o_last          = w_obeat.last;
    assign o_dropped_total = w_obeat.dropped_total;

    a_ring_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_used <= RD_P)
        else $error("byte ring holds more than its depth");

    a_mark_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mused <= MD_P)
        else $error("mark ring holds more than its depth");

    a_last_on_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_beat.last) |-> w_beat.frame_end)
        else $error("last beat is not a closing flag");

    a_seq_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seq != n_seq) |-> (r_state == tbrf_pkg::S_FIT && w_fits))
        else $error("sequence moved outside a committed frame");

    a_idle_no_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tbrf_pkg::S_IDLE) |-> !w_load)
        else $error("beat loaded while idle");

endmodule
`default_nettype wire
